// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the stack permutation checker.
package spc_pkg;

  localparam int VAL_W  = 13;
  localparam int NEXT_W = VAL_W + 1;
  localparam int RUN_W  = 2 * VAL_W;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [VAL_W-1:0] from_value;
    logic [VAL_W-1:0] to_value;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } oq_push_t;

endpackage

// ===== rtl/spc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module spc_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/spc_outq.sv =====
// Four-entry result queue taking up to two results a cycle.
module spc_outq (
  input  logic              clk,
  input  logic              rst,
  input  spc_pkg::oq_push_t push,
  output logic              room,
  output logic              out_valid,
  output spc_pkg::result_t  out_item,
  input  logic              out_ready
);
  import spc_pkg::*;

  result_t    entries [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic [2:0] n_push;
  logic       pop;

  assign n_push    = {2'd0, push.first_valid} + {2'd0, push.second_valid};
  assign out_valid = (count != 3'd0);
  assign out_item  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      entries[2'(wr_ptr + 2'd1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + n_push - {2'd0, pop};
    end
  end

endmodule

// ===== rtl/stack_permutation_checker_core.sv =====
// Top level of the stack permutation checker: run stack control and ports.
//
//   channel  direction  handshake                 payload
//   s_       in         s_tvalid / s_tready       s_tuser restart, s_tdata target
//   m_       out        m_tvalid / m_tready       m_tuser kind, m_tdata from/to, m_tlast
//   cfg_     in         cfg_valid / cfg_ready     cfg_data seq_length
//
// An item passes through ST_REFILL as well when a pop empties the top run
// held in registers and the run below it is read back from the stack memory.
// The stack memory keeps runs of consecutive values, one entry per run.
// Reset clears the control state only; the memory needs no clearing pass.
// A stalled output holds the results in a four-entry queue; a new item is
// taken while at least two places in it are free.
module stack_permutation_checker_core #(
  parameter int MAX_LEN = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] target, rest zero
  input  logic [0:0]  s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [12:0] from_value, [25:13] to_value, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  import spc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic {ST_IDLE, ST_REFILL} state_t;

  state_t            state, state_next;
  logic [VAL_W-1:0]  seq_len;
  logic [CW-1:0]     run_cnt, run_cnt_next;
  logic              top_valid, top_valid_next;
  logic [VAL_W-1:0]  top_lo, top_lo_next;
  logic [VAL_W-1:0]  top_hi, top_hi_next;
  logic [NEXT_W-1:0] next_push, next_push_next;
  logic              rejected, rejected_next;

  logic              accept;
  logic              restart;
  logic [VAL_W-1:0]  target;
  logic              eff_rej;
  logic              eff_top_valid;
  logic [NEXT_W-1:0] eff_next;
  logic [CW-1:0]     eff_cnt;
  logic              out_of_range;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [RUN_W-1:0]  ram_rd_data;
  oq_push_t          oq_push;
  logic              oq_room;
  logic              oq_valid;
  result_t           oq_item;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && oq_room;
  assign accept    = s_tvalid && s_tready;
  assign restart   = s_tuser[0];
  assign target    = s_tdata[VAL_W-1:0];

  assign eff_rej       = restart ? 1'b0 : rejected;
  assign eff_top_valid = restart ? 1'b0 : top_valid;
  assign eff_next      = restart ? NEXT_W'(1) : next_push;
  assign eff_cnt       = restart ? '0 : run_cnt;
  assign out_of_range  = (target == '0) || (target > seq_len) || (32'(target) > MAX_LEN);

  always_comb begin
    state_next     = state;
    run_cnt_next   = run_cnt;
    top_valid_next = top_valid;
    top_lo_next    = top_lo;
    top_hi_next    = top_hi;
    next_push_next = next_push;
    rejected_next  = rejected;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    oq_push        = '0;
    oq_push.first  = '{kind: KIND_REJECT, from_value: '0, to_value: '0, last: 1'b1};
    oq_push.second = '{kind: KIND_POP, from_value: target, to_value: target, last: 1'b1};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          oq_push.first_valid = 1'b1;
          run_cnt_next        = eff_cnt;
          top_valid_next      = eff_top_valid;
          next_push_next      = eff_next;
          rejected_next       = eff_rej;
          priority if (eff_rej || out_of_range) begin
            rejected_next = 1'b1;
          end else if ({1'b0, target} >= eff_next) begin
            oq_push.second_valid = 1'b1;
            oq_push.first = '{kind: KIND_PUSH, from_value: eff_next[VAL_W-1:0],
                              to_value: target, last: 1'b0};
            next_push_next = {1'b0, target} + NEXT_W'(1);
            if ({1'b0, target} != eff_next) begin
              ram_wr_en      = eff_top_valid;
              run_cnt_next   = eff_top_valid ? eff_cnt + CW'(1) : eff_cnt;
              top_valid_next = 1'b1;
              top_lo_next    = eff_next[VAL_W-1:0];
              top_hi_next    = target - VAL_W'(1);
            end
          end else if (!eff_top_valid || (top_hi != target)) begin
            rejected_next = 1'b1;
          end else begin
            oq_push.first = oq_push.second;
            if (top_lo != top_hi) begin
              top_hi_next = top_hi - VAL_W'(1);
            end else if (eff_cnt != '0) begin
              ram_rd_en  = 1'b1;
              state_next = ST_REFILL;
            end else begin
              top_valid_next = 1'b0;
            end
          end
        end
      end
      ST_REFILL: begin
        top_lo_next    = ram_rd_data[RUN_W-1:VAL_W];
        top_hi_next    = ram_rd_data[VAL_W-1:0];
        top_valid_next = 1'b1;
        run_cnt_next   = run_cnt - CW'(1);
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    top_lo <= top_lo_next;
    top_hi <= top_hi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seq_len   <= VAL_W'(1);
      run_cnt   <= '0;
      top_valid <= 1'b0;
      next_push <= NEXT_W'(1);
      rejected  <= 1'b0;
    end else begin
      state     <= state_next;
      run_cnt   <= run_cnt_next;
      top_valid <= top_valid_next;
      next_push <= next_push_next;
      rejected  <= rejected_next;
      if (cfg_valid && cfg_ready) begin
        seq_len <= cfg_data;
      end
    end
  end

  spc_ram #(
    .WIDTH(RUN_W),
    .DEPTH(MAX_LEN)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(eff_cnt[AW-1:0]),
    .wr_data({top_lo, top_hi}),
    .rd_en  (ram_rd_en),
    .rd_addr(run_cnt_next[AW-1:0] - AW'(1)),
    .rd_data(ram_rd_data)
  );

  spc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (oq_push),
    .room     (oq_room),
    .out_valid(oq_valid),
    .out_item (oq_item),
    .out_ready(m_tready)
  );

  assign m_tvalid = oq_valid;
  assign m_tuser  = oq_item.kind;
  assign m_tlast  = oq_item.last;
  assign m_tdata  = {6'd0, oq_item.to_value, oq_item.from_value};

  a_refill_loads_top: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REFILL) |=> (top_valid && (state == ST_IDLE)))
    else $error("refill did not load the top run");

  a_top_below_next: assert property (@(posedge clk) disable iff (rst)
    top_valid |-> (({1'b0, top_hi} < next_push) && (top_lo <= top_hi)))
    else $error("top run not below the next value to push");

  a_refill_has_entry: assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |-> (run_cnt_next != '0))
    else $error("stack memory read with no stored run");

  a_push_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == KIND_PUSH))
    else $error("only a push run may precede another result of its item");

endmodule
